// ===== rtl/sqc_pkg.sv =====
// Shared types and constants of the square shift cipher.
package sqc_pkg;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECRYPT = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_TRANSLATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MARKER     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SIDE     = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = 7'd64;
    localparam logic [LEN_W-1:0] ROW_SIDE_RESET     = 7'd8;

    // The marker byte that passes unchanged.
    localparam logic [CHAR_W-1:0] MARKER_BYTE = 8'h3E;

endpackage

// ===== rtl/sqc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/square_shift_cipher.sv =====
// Square shift cipher top level: table RAM, search sequencer and result register.
//
// Usage: items enter on the input channel (in_valid, in_stall) with command,
// entry_index and char_in; one result beat per item leaves on the output
// channel (out_valid, out_stall) with char_out and status. A beat moves at an
// edge where valid is high and stall is low.
// A load, a marker byte or a reserved command is answered in the cycle after it
// is accepted, and the next item may follow in the next cycle.
// An encrypt or decrypt beat scans the table RAM one entry per cycle through
// its single read port (effective length, limited to MAX_SQUARE), then passes
// the drain and shift states; a translated byte is fetched from the shifted
// entry, while a byte missing from the table skips the fetch. The result waits
// in the done state until the output register is free; then the next item may
// come. With a length of zero the byte is flagged absent without a scan. One item is in work.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready and should be issued only while the block is idle.
// Reset sets table_length to 64 and row_side to 8 and empties the output
// register; the table contents stay undefined until loaded. While the
// receiver stalls, the result beat holds and no new item is accepted.
module square_shift_cipher #(
    parameter int MAX_SQUARE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sqc_pkg::CMD_W-1:0]       command,
    input  logic [sqc_pkg::IDX_W-1:0]       entry_index,
    input  logic [sqc_pkg::CHAR_W-1:0]      char_in,
    // Output channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sqc_pkg::CHAR_W-1:0]      char_out,
    output logic [sqc_pkg::STATUS_W-1:0]    status,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sqc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sqc_pkg::LEN_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SQUARE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_SHIFT,
        S_FETCH,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [sqc_pkg::LEN_W-1:0]       table_length_reg, table_length_next;
    logic [sqc_pkg::LEN_W-1:0]       row_side_reg, row_side_next;
    logic [sqc_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [sqc_pkg::LEN_W-1:0]       side_reg, side_next;
    logic [sqc_pkg::LEN_W-1:0]       scan_reg, scan_next;
    logic [sqc_pkg::LEN_W-1:0]       cmp_pos_reg, cmp_pos_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [sqc_pkg::LEN_W-1:0]       pos_reg, pos_next;
    logic                            hit_reg, hit_next;
    logic                            decrypt_reg, decrypt_next;
    logic [sqc_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic [sqc_pkg::CHAR_W-1:0]      res_char_reg, res_char_next;
    logic [sqc_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sqc_pkg::CHAR_W-1:0]      char_out_reg, char_out_next;
    logic [sqc_pkg::STATUS_W-1:0]    status_reg, status_next;

    logic                            out_free;
    logic                            in_accept;
    logic [sqc_pkg::LEN_W-1:0]       len_eff;
    logic [sqc_pkg::LEN_W-1:0]       side_eff;
    logic [sqc_pkg::LEN_W:0]         enc_sum;
    logic [sqc_pkg::LEN_W:0]         dst_wide;
    logic [sqc_pkg::LEN_W-1:0]       dst;
    logic                            ram_wr_en;
    logic [ADDR_W-1:0]               ram_rd_addr;
    logic [sqc_pkg::CHAR_W-1:0]      ram_rd_data;

    // Handshake signals.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign status    = status_reg;

    // Effective length and clamped shift, taken when a byte is accepted.
    always_comb
    begin
        if (32'(table_length_reg) > MAX_SQUARE)
        begin
            len_eff = sqc_pkg::LEN_W'(MAX_SQUARE);
        end
        else
        begin
            len_eff = table_length_reg;
        end
        side_eff = (row_side_reg > len_eff) ? len_eff : row_side_reg;
    end

    // Destination position, wrapped over the effective length.
    always_comb
    begin
        enc_sum = {1'b0, pos_reg} + {1'b0, side_reg};
        if (!decrypt_reg)
        begin
            dst_wide = (enc_sum >= {1'b0, len_reg}) ? enc_sum - {1'b0, len_reg} : enc_sum;
        end
        else if (pos_reg >= side_reg)
        begin
            dst_wide = {1'b0, pos_reg} - {1'b0, side_reg};
        end
        else
        begin
            dst_wide = {1'b0, pos_reg} + {1'b0, len_reg} - {1'b0, side_reg};
        end
        dst = dst_wide[sqc_pkg::LEN_W-1:0];
    end

    // Table RAM: loads write, the sequencer reads.
    assign ram_wr_en   = in_accept && (command == sqc_pkg::CMD_LOAD)
                         && (32'(entry_index) < MAX_SQUARE);
    assign ram_rd_addr = (state_reg == S_SHIFT) ? ADDR_W'(dst) : ADDR_W'(scan_reg);

    sqc_ram #(
        .WIDTH (sqc_pkg::CHAR_W),
        .DEPTH (MAX_SQUARE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (char_in),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer, configuration registers and output register.
    always_comb
    begin
        state_next        = state_reg;
        table_length_next = table_length_reg;
        row_side_next     = row_side_reg;
        len_next          = len_reg;
        side_next         = side_reg;
        scan_next         = scan_reg;
        cmp_pos_next      = scan_reg;
        cmp_valid_next    = (state_reg == S_SEARCH);
        pos_next          = pos_reg;
        hit_next          = hit_reg;
        decrypt_next      = decrypt_reg;
        char_next         = char_reg;
        res_char_next     = res_char_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && out_stall;
        char_out_next     = char_out_reg;
        status_next       = status_reg;

        // Configuration writes.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sqc_pkg::REG_TABLE_LENGTH: table_length_next = cfg_data;
                sqc_pkg::REG_ROW_SIDE:     row_side_next = cfg_data;
                default:                   ;
            endcase
        end

        // Compare the entry read in the previous cycle; the last match wins.
        if (cmp_valid_reg && (ram_rd_data == char_reg))
        begin
            hit_next = 1'b1;
            pos_next = cmp_pos_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    char_next    = char_in;
                    decrypt_next = (command == sqc_pkg::CMD_DECRYPT);
                    len_next     = len_eff;
                    side_next    = side_eff;
                    scan_next    = '0;
                    hit_next     = 1'b0;
                    char_out_next = char_in;
                    if (command == sqc_pkg::CMD_LOAD)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = sqc_pkg::ST_LOADED;
                    end
                    else if ((command != sqc_pkg::CMD_ENCRYPT)
                             && (command != sqc_pkg::CMD_DECRYPT))
                    begin
                        out_valid_next = 1'b1;
                        status_next    = sqc_pkg::ST_ABSENT;
                    end
                    else if (char_in == sqc_pkg::MARKER_BYTE)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = sqc_pkg::ST_MARKER;
                    end
                    else if (len_eff == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = sqc_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == len_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (hit_reg)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    res_char_next   = char_reg;
                    res_status_next = sqc_pkg::ST_ABSENT;
                    state_next      = S_DONE;
                end
            end
            S_FETCH:
            begin
                res_char_next   = ram_rd_data;
                res_status_next = sqc_pkg::ST_TRANSLATED;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_out_next  = res_char_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            table_length_reg <= sqc_pkg::TABLE_LENGTH_RESET;
            row_side_reg     <= sqc_pkg::ROW_SIDE_RESET;
            len_reg          <= '0;
            side_reg         <= '0;
            scan_reg         <= '0;
            cmp_pos_reg      <= '0;
            cmp_valid_reg    <= 1'b0;
            pos_reg          <= '0;
            hit_reg          <= 1'b0;
            decrypt_reg      <= 1'b0;
            char_reg         <= '0;
            res_char_reg     <= '0;
            res_status_reg   <= '0;
            out_valid_reg    <= 1'b0;
            char_out_reg     <= '0;
            status_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            table_length_reg <= table_length_next;
            row_side_reg     <= row_side_next;
            len_reg          <= len_next;
            side_reg         <= side_next;
            scan_reg         <= scan_next;
            cmp_pos_reg      <= cmp_pos_next;
            cmp_valid_reg    <= cmp_valid_next;
            pos_reg          <= pos_next;
            hit_reg          <= hit_next;
            decrypt_reg      <= decrypt_next;
            char_reg         <= char_next;
            res_char_reg     <= res_char_next;
            res_status_reg   <= res_status_next;
            out_valid_reg    <= out_valid_next;
            char_out_reg     <= char_out_next;
            status_reg       <= status_next;
        end
    end

`ifndef SYNTHESIS
    // Only an idle sequencer with a free output register takes a beat.
    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while a search is in work");

    // A load is answered in the next cycle with the load status.
    a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == sqc_pkg::CMD_LOAD)) |=>
        (out_valid && (status == sqc_pkg::ST_LOADED)))
        else $error("load beat not answered in the next cycle");

    // The scan never reads beyond the effective length.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (scan_reg < len_reg))
        else $error("scan address beyond the effective length");

    // The wrapped destination stays inside the effective length.
    a_dst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SHIFT) && hit_reg) |-> (dst < len_reg))
        else $error("destination position beyond the effective length");

    // A result waiting in the done state is never dropped by a new beat.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !out_free) |=> (state_reg == S_DONE))
        else $error("finished result left the done state while blocked");
`endif

endmodule
